// File: sv/igs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// igs_pkg
// Shared constants, result struct and log2 table builder for the scorer.
// ----------------------------------------------------------------------------
package igs_pkg;

  localparam int COUNT_BITS_DEF     = 16;
  localparam int LOG_TABLE_BITS_DEF = 8;

  localparam int PREC_W   = 20;
  localparam int SCORE_W  = 21;
  localparam int THR_W    = 22;
  localparam int ENT_W    = 32;
  localparam int P_W      = 25;   // Q1.24 probability, 1.0 included
  localparam int Q_FRAC   = 24;
  localparam int RCP_FRAC = 30;

  localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(100000);
  localparam logic [29:0]       LN2_Q30    = 30'd744261118;

  localparam logic OP_SCORE = 1'b0;
  localparam logic OP_BOUND = 1'b1;

  // latencies in register stages
  localparam int DIV_LAT  = Q_FRAC + 1;
  localparam int RCP_LAT  = RCP_FRAC + 1;
  localparam int ENT_LAT  = DIV_LAT + 10;
  localparam int POST_LAT = 7;
  localparam int LANE_LAT = ENT_LAT + POST_LAT;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               bad;
  } lane_res_t;

  // log2(1 + k/2^tb) in Q30 by repeated squaring; entry past the end is 1.0
  function automatic logic [30:0] log_rom(input int unsigned k, input int unsigned tb);
    logic [63:0] y;
    logic [30:0] r;
    r = '0;
    if (k >= (32'd1 << tb)) begin
      return 31'h4000_0000;
    end
    y = (64'd1 << 30) + (64'(k) << (30 - tb));
    for (int i = 1; i <= 30; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        r[30-i] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/igs_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// igs_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module igs_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q_o = sr_r[DEPTH-1];

endmodule
`default_nettype wire

// File: sv/igs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// igs_div
// Pipelined restoring divider: floor(num * 2^FRAC / den), num <= den.
// One quotient bit per stage.
// ----------------------------------------------------------------------------
module igs_div #(
  parameter int BW   = 17,
  parameter int FRAC = 24
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [BW-1:0] num_i,
  input  wire logic [BW-1:0] den_i,
  output logic      [FRAC:0] quo_o
);

  localparam int ST = FRAC + 1;

  logic [BW-1:0] rem_r [ST];
  logic [BW-1:0] den_r [ST];
  logic [FRAC:0] quo_r [ST];

  for (genvar i = 0; i < ST; i++) begin : g_st
    logic          qb;
    logic [BW:0]   trial;
    logic [BW-1:0] rem_nxt;
    logic [FRAC:0] quo_nxt;
    if (i == 0) begin : g_first
      always_comb begin
        trial   = {1'b0, num_i};
        qb      = (num_i >= den_i);
        rem_nxt = qb ? (num_i - den_i) : num_i;
        quo_nxt = {{FRAC{1'b0}}, qb};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[i] <= den_i;
        end
      end
    end else begin : g_next
      always_comb begin
        trial   = {rem_r[i-1], 1'b0};
        qb      = (trial >= {1'b0, den_r[i-1]});
        rem_nxt = qb ? BW'(trial - {1'b0, den_r[i-1]}) : trial[BW-1:0];
        quo_nxt = {quo_r[i-1][FRAC-1:0], qb};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[i] <= den_r[i-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        quo_r[i] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[ST-1];

endmodule
`default_nettype wire

// File: sv/igs_ent.sv
`default_nettype none
// ----------------------------------------------------------------------------
// igs_ent
// Entropy term -p*log2(p) in Q30 for p = num/den, with p passed along.
// Divide, normalize, table lookup with interpolation, then scale by p.
// ----------------------------------------------------------------------------
module igs_ent #(
  parameter int BW = 17,
  parameter int TB = 8
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [BW-1:0]            num_i,
  input  wire logic [BW-1:0]            den_i,
  output logic      [igs_pkg::ENT_W-1:0] ent_o,
  output logic      [igs_pkg::P_W-1:0]   p_o
);

  import igs_pkg::*;

  localparam int RW = Q_FRAC - TB;

  logic [P_W-1:0] q;

  igs_div #(.BW(BW), .FRAC(Q_FRAC)) u_div (
    .clk(clk), .en(en), .num_i(num_i), .den_i(den_i), .quo_o(q)
  );

  // normalize: shift left until the top bit is set
  logic [P_W-1:0] nm_r [5];
  logic [4:0]     ne_r [5];
  logic [P_W-1:0] np_r [5];

  for (genvar j = 0; j < 5; j++) begin : g_norm
    localparam int SH = 16 >> j;
    logic [P_W-1:0] src_m;
    logic [4:0]     src_e;
    logic [P_W-1:0] src_p;
    logic           hit;
    if (j == 0) begin : g_a
      assign src_m = q;
      assign src_e = '0;
      assign src_p = q;
    end else begin : g_b
      assign src_m = nm_r[j-1];
      assign src_e = ne_r[j-1];
      assign src_p = np_r[j-1];
    end
    assign hit = (src_m[P_W-1 -: SH] == '0);
    always_ff @(posedge clk) begin
      if (en) begin
        nm_r[j] <= hit ? (src_m << SH) : src_m;
        ne_r[j] <= hit ? 5'(src_e + 5'(SH)) : src_e;
        np_r[j] <= src_p;
      end
    end
  end

  // log2 mantissa table
  logic [30:0] rom [2**TB+1];
  for (genvar g = 0; g <= 2**TB; g++) begin : g_rom
    localparam logic [30:0] V = log_rom(g, TB);
    assign rom[g] = V;
  end

  logic [TB-1:0] k;
  logic [RW-1:0] rmd;
  logic [TB:0]   k1;
  assign k   = nm_r[4][Q_FRAC-1 -: TB];
  assign rmd = nm_r[4][RW-1:0];
  assign k1  = {1'b0, k} + 1'b1;

  logic [30:0]    lo_r, dif_r;
  logic [RW-1:0]  rmd_r;
  logic [4:0]     e1_r;
  logic [P_W-1:0] p1_r;
  logic           z1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= rom[k];
      dif_r <= rom[k1] - rom[k];
      rmd_r <= rmd;
      e1_r  <= ne_r[4];
      p1_r  <= np_r[4];
      z1_r  <= (nm_r[4] == '0);
    end
  end

  // interpolate
  logic [30+RW:0] ip;
  assign ip = (30+RW+1)'(dif_r) * (30+RW+1)'(rmd_r);

  logic [30:0]    ip_r, lo2_r;
  logic [4:0]     e2_r;
  logic [P_W-1:0] p2_r;
  logic           z2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ip_r  <= ip[RW +: 31];
      lo2_r <= lo_r;
      e2_r  <= e1_r;
      p2_r  <= p1_r;
      z2_r  <= z1_r;
    end
  end

  logic [34:0] negl_r;
  logic [P_W-1:0] p3_r;
  logic           z3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      negl_r <= {e2_r, 30'b0} - (35'(lo2_r) + 35'(ip_r));
      p3_r   <= p2_r;
      z3_r   <= z2_r;
    end
  end

  // scale by p in two partial products
  logic [42:0]    pl_r;
  logic [41:0]    ph_r;
  logic [P_W-1:0] p4_r;
  logic           z4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= 43'(p3_r) * 43'(negl_r[17:0]);
      ph_r <= 42'(p3_r) * 42'(negl_r[34:18]);
      p4_r <= p3_r;
      z4_r <= z3_r;
    end
  end

  logic [60:0] psum;
  assign psum = 61'(pl_r) + (61'(ph_r) << 18);

  logic [ENT_W-1:0] ent_r;
  logic [P_W-1:0]   p5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= z4_r ? '0 : psum[Q_FRAC +: ENT_W];
      p5_r  <= p4_r;
    end
  end

  assign ent_o = ent_r;
  assign p_o   = p5_r;

endmodule
`default_nettype wire

// File: sv/igs_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// igs_lane
// Scaled information gain of one split placement, with its validity flag.
// ----------------------------------------------------------------------------
module igs_lane #(
  parameter int COUNT_BITS     = igs_pkg::COUNT_BITS_DEF,
  parameter int LOG_TABLE_BITS = igs_pkg::LOG_TABLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [COUNT_BITS-1:0]        x_i,
  input  wire logic [COUNT_BITS:0]          px_i,
  input  wire logic [COUNT_BITS-1:0]        y_i,
  input  wire logic [COUNT_BITS:0]          py_i,
  input  wire logic [igs_pkg::PREC_W-1:0]   precision_i,
  output igs_pkg::lane_res_t                res_o
);

  import igs_pkg::*;

  localparam int HW = COUNT_BITS + 1;

  logic [HW-1:0] tot, pos, neg, xr, yr;
  logic          bad, spc;

  always_comb begin
    tot = {1'b0, x_i} + {1'b0, y_i};
    pos = HW'(px_i + py_i);
    neg = tot - pos;
    xr  = {1'b0, x_i} - px_i;
    yr  = {1'b0, y_i} - py_i;
    bad = (tot == '0) || (px_i > {1'b0, x_i}) || (py_i > {1'b0, y_i});
    spc = (pos == '0) || (neg == '0);
  end

  logic [ENT_W-1:0] e_x, e_y, e_hp, e_hq, e_nx, e_ny;
  logic [P_W-1:0]   r_pos, r_neg;

  igs_ent #(.BW(HW), .TB(LOG_TABLE_BITS)) u_ex (
    .clk(clk), .en(en), .num_i({1'b0, x_i}), .den_i(tot), .ent_o(e_x), .p_o()
  );
  igs_ent #(.BW(HW), .TB(LOG_TABLE_BITS)) u_ey (
    .clk(clk), .en(en), .num_i({1'b0, y_i}), .den_i(tot), .ent_o(e_y), .p_o()
  );
  igs_ent #(.BW(HW), .TB(LOG_TABLE_BITS)) u_rp (
    .clk(clk), .en(en), .num_i(pos), .den_i(tot), .ent_o(), .p_o(r_pos)
  );
  igs_ent #(.BW(HW), .TB(LOG_TABLE_BITS)) u_rn (
    .clk(clk), .en(en), .num_i(neg), .den_i(tot), .ent_o(), .p_o(r_neg)
  );
  igs_ent #(.BW(HW), .TB(LOG_TABLE_BITS)) u_hp (
    .clk(clk), .en(en), .num_i(HW'(px_i)), .den_i(pos), .ent_o(e_hp), .p_o()
  );
  igs_ent #(.BW(HW), .TB(LOG_TABLE_BITS)) u_hq (
    .clk(clk), .en(en), .num_i(HW'(py_i)), .den_i(pos), .ent_o(e_hq), .p_o()
  );
  igs_ent #(.BW(HW), .TB(LOG_TABLE_BITS)) u_nx (
    .clk(clk), .en(en), .num_i(xr), .den_i(neg), .ent_o(e_nx), .p_o()
  );
  igs_ent #(.BW(HW), .TB(LOG_TABLE_BITS)) u_ny (
    .clk(clk), .en(en), .num_i(yr), .den_i(neg), .ent_o(e_ny), .p_o()
  );

  // 2^30 / total for the empty-side case
  logic [RCP_FRAC:0] rcp, rcp_d;

  igs_div #(.BW(HW), .FRAC(RCP_FRAC)) u_rcp (
    .clk(clk), .en(en), .num_i(HW'(1)), .den_i(tot), .quo_o(rcp)
  );

  igs_delay #(.W(RCP_FRAC+1), .DEPTH(ENT_LAT-RCP_LAT)) u_rcp_d (
    .clk(clk), .en(en), .d_i(rcp), .q_o(rcp_d)
  );

  logic spc_d, bad_d;

  igs_delay #(.W(1), .DEPTH(ENT_LAT)) u_spc_d (
    .clk(clk), .en(en), .d_i(spc), .q_o(spc_d)
  );
  igs_delay #(.W(1), .DEPTH(LANE_LAT)) u_bad_d (
    .clk(clk), .en(en), .d_i(bad), .q_o(bad_d)
  );

  // combine terms
  logic [ENT_W-1:0]  base1_r, sp1_r, sn1_r, base2_r, base3_r;
  logic [P_W-1:0]    rp1_r, rn1_r;
  logic              spc1_r, spc2_r, spc3_r;
  logic [RCP_FRAC:0] rcp1_r, rcp2_r, rcp3_r, rsel4_r;
  logic [40:0]       pal_r, pah_r, pbl_r, pbh_r;
  logic [33:0]       cond3_r;
  logic [61:0]       prod4_r;
  logic [32:0]       g5_r;
  logic [52:0]       r6_r;
  logic [SCORE_W-1:0] score7_r;

  logic [57:0]      cond_full;
  logic [ENT_W-1:0] diff;

  always_comb begin
    cond_full = 58'(pal_r) + (58'(pah_r) << 16) + 58'(pbl_r) + (58'(pbh_r) << 16);
    if (spc3_r) begin
      diff = base3_r;
    end else if (cond3_r >= {2'b0, base3_r}) begin
      diff = '0;
    end else begin
      diff = base3_r - cond3_r[ENT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base1_r  <= ENT_W'(e_x + e_y);
      sp1_r    <= ENT_W'(e_hp + e_hq);
      sn1_r    <= ENT_W'(e_nx + e_ny);
      rp1_r    <= r_pos;
      rn1_r    <= r_neg;
      spc1_r   <= spc_d;
      rcp1_r   <= rcp_d;

      pal_r    <= 41'(rp1_r) * 41'(sp1_r[15:0]);
      pah_r    <= 41'(rp1_r) * 41'(sp1_r[31:16]);
      pbl_r    <= 41'(rn1_r) * 41'(sn1_r[15:0]);
      pbh_r    <= 41'(rn1_r) * 41'(sn1_r[31:16]);
      base2_r  <= base1_r;
      spc2_r   <= spc1_r;
      rcp2_r   <= rcp1_r;

      cond3_r  <= cond_full[Q_FRAC +: 34];
      base3_r  <= base2_r;
      spc3_r   <= spc2_r;
      rcp3_r   <= rcp2_r;

      prod4_r  <= 62'(diff) * 62'(LN2_Q30);
      rsel4_r  <= spc3_r ? rcp3_r : '0;

      g5_r     <= 33'(prod4_r[61:30]) + 33'(rsel4_r);

      r6_r     <= 53'(precision_i) * 53'(g5_r);

      score7_r <= (|r6_r[52:51]) ? '1 : r6_r[50:30];
    end
  end

  assign res_o.score = score7_r;
  assign res_o.bad   = bad_d;

endmodule
`default_nettype wire

// File: sv/information_gain_scorer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// information_gain_scorer_core
// Two-class information gain of a binary split, scaled by a precision
// register, with a bound check that scores both extreme placements.
// ----------------------------------------------------------------------------
//
//  channel  handshake        payload
//  -------  ---------------  ------------------------------------------------
//  in       valid / stall    operation, class counts, bounds, threshold
//  out      valid / stall    score, below_threshold, invalid
//  cfg      valid / ready    precision write data (always ready)
//
//  One item enters per cycle while the output is not stalled; every result
//  passes the input register, 42-stage scoring lane and output register.
//  The depth is set by the 25-stage entropy dividers, one quotient bit per stage, and the log stages.
//  Synchronous active-low reset clears the valid bits and sets precision.
//  A stalled result freezes the whole pipeline; no item is lost or repeated.
//
module information_gain_scorer_core #(
  parameter int COUNT_BITS     = igs_pkg::COUNT_BITS_DEF,
  parameter int LOG_TABLE_BITS = igs_pkg::LOG_TABLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,

  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_operation,
  input  wire logic [COUNT_BITS-1:0]              in_class0_total,
  input  wire logic [COUNT_BITS-1:0]              in_class0_hit,
  input  wire logic [COUNT_BITS-1:0]              in_class1_total,
  input  wire logic [COUNT_BITS-1:0]              in_class1_hit,
  input  wire logic [COUNT_BITS-1:0]              in_bound_x,
  input  wire logic [COUNT_BITS-1:0]              in_bound_y,
  input  wire logic signed [igs_pkg::THR_W-1:0]   in_threshold,

  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [igs_pkg::PREC_W-1:0]         cfg_data,

  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [igs_pkg::SCORE_W-1:0]             out_score,
  output logic                                    out_below_threshold,
  output logic                                    out_invalid
);

  import igs_pkg::*;

  // output register valid bit, needed by the advance logic below
  logic out_valid_r;

  // advance everything whenever the output slot is free or being taken
  logic adv;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // precision register; the sender writes it only while the pipeline is empty
  logic [PREC_W-1:0] prec_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r <= PREC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      prec_r <= cfg_data;
    end
  end

  // input register
  logic                  iv_r;
  logic                  op_r;
  logic [COUNT_BITS-1:0] x_r, px_r, y_r, py_r, bx_r, by_r;
  logic [THR_W-1:0]      thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (adv) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r  <= in_operation;
      x_r   <= in_class0_total;
      px_r  <= in_class0_hit;
      y_r   <= in_class1_total;
      py_r  <= in_class1_hit;
      bx_r  <= in_bound_x;
      by_r  <= in_bound_y;
      thr_r <= in_threshold;
    end
  end

  // lane A scores the split itself or the placement with all bound hits in
  // the second class; lane B takes the placement with all hits in the first
  logic [COUNT_BITS:0] s, pxa, pya;

  always_comb begin
    s = {1'b0, bx_r} + {1'b0, by_r};
    if (op_r == OP_BOUND) begin
      pxa = '0;
      pya = s;
    end else begin
      pxa = {1'b0, px_r};
      pya = {1'b0, py_r};
    end
  end

  lane_res_t res_a, res_b;

  igs_lane #(.COUNT_BITS(COUNT_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lane_a (
    .clk(clk), .en(adv), .x_i(x_r), .px_i(pxa), .y_i(y_r), .py_i(pya),
    .precision_i(prec_r), .res_o(res_a)
  );

  igs_lane #(.COUNT_BITS(COUNT_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lane_b (
    .clk(clk), .en(adv), .x_i(x_r), .px_i(s), .y_i(y_r), .py_i('0),
    .precision_i(prec_r), .res_o(res_b)
  );

  // carry operation and threshold alongside the lanes
  logic [THR_W:0] side_d;

  igs_delay #(.W(THR_W+1), .DEPTH(LANE_LAT)) u_side_d (
    .clk(clk), .en(adv), .d_i({op_r, thr_r}), .q_o(side_d)
  );

  // valid bits travel with the data
  logic [LANE_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LANE_LAT-2:0], iv_r};
    end
  end

  // merge the two lanes
  logic               op_d, bad, lt_a, lt_b;
  logic [SCORE_W-1:0] score_nxt;
  logic               below_nxt;

  always_comb begin
    op_d = side_d[THR_W];
    bad  = res_a.bad || ((op_d == OP_BOUND) && res_b.bad);
    lt_a = $signed({1'b0, res_a.score}) < $signed(side_d[THR_W-1:0]);
    lt_b = $signed({1'b0, res_b.score}) < $signed(side_d[THR_W-1:0]);
    if (bad) begin
      score_nxt = '0;
      below_nxt = 1'b0;
    end else if (op_d == OP_BOUND) begin
      score_nxt = (res_a.score > res_b.score) ? res_a.score : res_b.score;
      below_nxt = lt_a && lt_b;
    end else begin
      score_nxt = res_a.score;
      below_nxt = 1'b0;
    end
  end

  // output register
  logic [SCORE_W-1:0] score_r;
  logic               below_r, invalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      score_r   <= score_nxt;
      below_r   <= below_nxt;
      invalid_r <= bad;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_score           = score_r;
  assign out_below_threshold = below_r;
  assign out_invalid         = invalid_r;

endmodule
`default_nettype wire
